/* rtl/dns_query_name_encoder_macros.svh */
// assertion macros for the dns query name encoder
`ifndef DNS_QUERY_NAME_ENCODER_MACROS_SVH
`define DNS_QUERY_NAME_ENCODER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define DQNE_ASSERT_IMPLIES(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: implication");

// next-cycle implication, checked out of reset
`define DQNE_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`else

`define DQNE_ASSERT_IMPLIES(label, clk, rst, lhs, rhs)
`define DQNE_ASSERT_NEXT(label, clk, rst, lhs, rhs)

`endif

`endif

/* rtl/dqne_pkg.sv */
package dqne_pkg;

   // name limit default
   localparam int MAX_NAME = 255;

   // header and encoding constants
   localparam logic [8:0] HDR_LEN      = 9'd12;
   localparam logic [7:0] DOT_CHAR     = 8'h2E;
   localparam logic [3:0] HDR_LAST     = 4'd11;
   localparam logic [2:0] END_LAST     = 3'd5;

   // function codes
   localparam logic [1:0] FUNC_START = 2'd0;
   localparam logic [1:0] FUNC_CHAR  = 2'd1;
   localparam logic [1:0] FUNC_END   = 2'd2;
   localparam logic [1:0] FUNC_NONE  = 2'd3;

   // register indexes
   localparam logic REG_TRANSACTION_ID = 1'b0;
   localparam logic REG_QUERY_TYPE     = 1'b1;

   localparam int CSR_ADDR_W = 3;

   typedef struct packed {
      logic [1:0] func;
      logic [7:0] name_char;
   } req_type;

   typedef struct packed {
      logic       write_enable;
      logic [8:0] address;
      logic [7:0] data;
      logic       last;
      logic       error;
      logic [8:0] total_length;
   } rsp_type;

   // fixed header bytes 2 to 11: flags 0x0100, qdcount 1, other counts 0
   function automatic logic [7:0] hdr_const_byte(input logic [3:0] idx);
      logic [7:0] b;
      b = 8'h00;
      unique case (idx)
         4'd2:    b = 8'h01;
         4'd5:    b = 8'h01;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* rtl/dns_query_name_encoder.sv */
// DNS query name encoder. Builds an A/IN style query into packet memory as a
// stream of (address, byte) writes on the rsp channel. A start item gives 12
// results (the header), a name character gives one, an end item gives 5 or 6
// (last label length, zero terminator, type, class) with the query size on
// the final one. Results leave at one per cycle from a single output
// register while rsp_stall is low; a stall holds the current result. A new
// item is taken in the same cycle the previous one hands over its final
// result, so a character stream runs at one character per cycle while the
// output does not stall. Characters past the name limit are dropped and
// flagged with error. Registers: transaction_id at byte address 0,
// query_type at byte address 4.
`include "dns_query_name_encoder_macros.svh"

module dns_query_name_encoder #(
   parameter int MaxName = dqne_pkg::MAX_NAME
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dqne_pkg::req_type                   req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dqne_pkg::rsp_type                   rsp_payload,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dqne_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [31:0]                         pwdata,
   output logic [31:0]                         prdata,
   output logic                                pready
);
   import dqne_pkg::*;

   localparam int NameCountW = $clog2(MaxName + 1);
   localparam logic [NameCountW-1:0] NameLimit = NameCountW'(MaxName);

   // configuration registers
   logic [15:0] transaction_id_ff, transaction_id_in;
   logic [15:0] query_type_ff, query_type_in;
   logic        csr_write;
   logic        csr_index;

   // current item and beat counter
   logic        item_valid_ff, item_valid_in;
   req_type     item_ff, item_in;
   logic [3:0]  beat_ff, beat_in;

   // name state
   logic [8:0]            label_start_ff, label_start_in;
   logic [7:0]            label_length_ff, label_length_in;
   logic [NameCountW-1:0] name_count_ff, name_count_in;

   // output register
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // datapath
   logic    advance, final_beat, done, accept;
   rsp_type res;
   logic       name_full, len_zero;
   logic [8:0] char_pos, end_base;
   logic [2:0] end_beat;

   // apb port
   assign csr_index = paddr[2];
   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign prdata    = (csr_index == REG_QUERY_TYPE) ? {16'h0000, query_type_ff}
                                                    : {16'h0000, transaction_id_ff};

   always_comb begin
      transaction_id_in = transaction_id_ff;
      query_type_in     = query_type_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_TRANSACTION_ID: transaction_id_in = pwdata[15:0];
            REG_QUERY_TYPE:     query_type_in     = pwdata[15:0];
            default:            ;
         endcase
      end
   end

   // handshake control
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign done      = advance && final_beat;
   assign req_stall = item_valid_ff && !done;
   assign accept    = req_valid && !req_stall;

   // result of the current beat
   assign name_full = (name_count_ff >= NameLimit);
   assign len_zero  = (label_length_ff == 8'd0);
   assign char_pos  = label_start_ff + 9'd1 + {1'b0, label_length_ff};
   assign end_base  = len_zero ? label_start_ff : char_pos;
   assign end_beat  = beat_ff[2:0] + {2'b00, len_zero};

   always_comb begin
      res             = '0;
      final_beat      = 1'b1;
      label_start_in  = label_start_ff;
      label_length_in = label_length_ff;
      name_count_in   = name_count_ff;
      unique case (item_ff.func)
         FUNC_START: begin
            res.write_enable = 1'b1;
            res.address      = {5'd0, beat_ff};
            unique case (beat_ff)
               4'd0:    res.data = transaction_id_ff[15:8];
               4'd1:    res.data = transaction_id_ff[7:0];
               default: res.data = hdr_const_byte(beat_ff);
            endcase
            final_beat = (beat_ff == HDR_LAST);
            res.last   = final_beat;
            if (done) begin
               label_start_in  = HDR_LEN;
               label_length_in = 8'd0;
               name_count_in   = '0;
            end
         end
         FUNC_CHAR: begin
            res.last = 1'b1;
            if (name_full) begin
               res.error = 1'b1;
            end else begin
               if (done) begin
                  name_count_in = name_count_ff + NameCountW'(1);
               end
               if (item_ff.name_char == DOT_CHAR) begin
                  if (!len_zero) begin
                     res.write_enable = 1'b1;
                     res.address      = label_start_ff;
                     res.data         = label_length_ff;
                     if (done) begin
                        label_start_in  = char_pos;
                        label_length_in = 8'd0;
                     end
                  end
               end else begin
                  res.write_enable = 1'b1;
                  res.address      = char_pos;
                  res.data         = item_ff.name_char;
                  if (done) begin
                     label_length_in = label_length_ff + 8'd1;
                  end
               end
            end
         end
         FUNC_END: begin
            res.write_enable = 1'b1;
            unique case (end_beat)
               3'd0: begin
                  res.address = label_start_ff;
                  res.data    = label_length_ff;
               end
               3'd1: begin
                  res.address = end_base;
                  res.data    = 8'h00;
               end
               3'd2: begin
                  res.address = end_base + 9'd1;
                  res.data    = query_type_ff[15:8];
               end
               3'd3: begin
                  res.address = end_base + 9'd2;
                  res.data    = query_type_ff[7:0];
               end
               3'd4: begin
                  res.address = end_base + 9'd3;
                  res.data    = 8'h00;
               end
               default: begin
                  res.address = end_base + 9'd4;
                  res.data    = 8'h01;
               end
            endcase
            final_beat = (end_beat == END_LAST);
            res.last   = final_beat;
            if (final_beat) begin
               res.total_length = end_base + 9'd5;
            end
            if (done) begin
               label_start_in  = HDR_LEN;
               label_length_in = 8'd0;
               name_count_in   = '0;
            end
         end
         default: begin
            res.last = 1'b1;
         end
      endcase
   end

   // item register and beat counter
   always_comb begin
      item_valid_in = item_valid_ff;
      item_in       = item_ff;
      beat_in       = beat_ff;
      if (accept) begin
         item_valid_in = 1'b1;
         item_in       = req_payload;
         beat_in       = 4'd0;
      end else if (done) begin
         item_valid_in = 1'b0;
      end else if (advance) begin
         beat_in = beat_ff + 4'd1;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         transaction_id_ff <= 16'h1234;
         query_type_ff     <= 16'h0001;
         item_valid_ff     <= 1'b0;
         beat_ff           <= 4'd0;
         label_start_ff    <= HDR_LEN;
         label_length_ff   <= 8'd0;
         name_count_ff     <= '0;
         rsp_valid_ff      <= 1'b0;
      end else begin
         transaction_id_ff <= transaction_id_in;
         query_type_ff     <= query_type_in;
         item_valid_ff     <= item_valid_in;
         beat_ff           <= beat_in;
         label_start_ff    <= label_start_in;
         label_length_ff   <= label_length_in;
         name_count_ff     <= name_count_in;
         rsp_valid_ff      <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // checks on the sequencer and result fields
   `DQNE_ASSERT_IMPLIES(a_multi_beat_func, clock, reset,
      item_valid_ff && (beat_ff != 4'd0),
      (item_ff.func == FUNC_START) || (item_ff.func == FUNC_END))
   `DQNE_ASSERT_IMPLIES(a_beat_range, clock, reset, item_valid_ff, beat_ff <= HDR_LAST)
   `DQNE_ASSERT_IMPLIES(a_size_on_last, clock, reset,
      rsp_valid_ff && (rsp_ff.total_length != 9'd0), rsp_ff.last)
   `DQNE_ASSERT_IMPLIES(a_error_no_write, clock, reset,
      rsp_valid_ff && rsp_ff.error, !rsp_ff.write_enable && rsp_ff.last)
   `DQNE_ASSERT_NEXT(a_done_frees_item, clock, reset,
      done && !accept, !item_valid_ff)

endmodule
